FILE: design/mte_pkg.sv
// Shared types and constants for the multi-tap echo core.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package mte_pkg;

    // Arithmetic format
    localparam int FRAC_BITS  = 12;
    localparam int CENTRE     = 2048;
    localparam int HIST_DEPTH = 4096;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    // Field widths
    localparam int SAMPLE_W = 12;
    localparam int OUT_W    = 16;
    localparam int HIST_W   = 13;
    localparam int CFG_DW   = 13;
    localparam int CFG_AW   = 3;
    localparam int DLY_W    = 12;
    localparam int DENS_W   = 13;
    localparam int GAIN_W   = 13;

    // Spacing divider: 2^FRAC_BITS / density, one quotient bit per step
    localparam int DIV_W     = FRAC_BITS + 1;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // Tap delay accumulator holds last delay plus one spacing
    localparam int DELAY_W = ((DLY_W > DIV_W) ? DLY_W : DIV_W) + 1;

    // Tap product and its shifted term
    localparam int PROD_W = GAIN_W + 1 + HIST_W;
    localparam int TERM_W = PROD_W - FRAC_BITS;

    // Register indexes
    typedef enum logic [CFG_AW-1:0] {
        REG_MAX_DELAY   = 3'd0,
        REG_FIRST_DELAY = 3'd1,
        REG_TAP_DENSITY = 3'd2,
        REG_FIRST_GAIN  = 3'd3,
        REG_GAIN_STEP   = 3'd4
    } cfg_idx_t;

    // Register reset values
    localparam logic [DLY_W-1:0]  RST_MAX_DELAY   = 12'd1024;
    localparam logic [DLY_W-1:0]  RST_FIRST_DELAY = 12'd0;
    localparam logic [DENS_W-1:0] RST_TAP_DENSITY = 13'd512;
    localparam logic [GAIN_W-1:0] RST_FIRST_GAIN  = 13'd2048;
    localparam logic [GAIN_W-1:0] RST_GAIN_STEP   = 13'd256;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic write_hist;
        logic div_init;
        logic div_step;
        logic tap_setup;
        logic tap_issue;
        logic load_out;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic tap_active;
        logic pipe_busy;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: design/mte_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module mte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: design/mte_ctrl.sv
// Sequencing controller for the multi-tap echo core.
// Depends on mte_pkg for command and status types and divider constants.
`default_nettype none

module mte_ctrl
    import mte_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire dp_stat_t  stat,
    output ctrl_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_DIVIDE,
        ST_SETUP,
        ST_TAPS,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [DIV_CNT_W-1:0]   cnt_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Decode commands and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.write_hist = 1'b1;
                cmd.div_init   = 1'b1;
                cnt_next       = '0;
                state_next     = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.tap_setup = 1'b1;
                state_next    = ST_TAPS;
            end
            ST_TAPS:
            begin
                if (stat.tap_active)
                begin
                    cmd.tap_issue = 1'b1;
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/mte_dp.sv
// Datapath of the multi-tap echo core: registers, spacing divider, tap
// pipeline, accumulator and output register. Depends on mte_pkg.
`default_nettype none

module mte_dp
    import mte_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // configuration writes
    input  wire logic                cfg_we,
    input  wire logic [CFG_AW-1:0]   cfg_addr,
    input  wire logic [CFG_DW-1:0]   cfg_data,
    // sample input and result output
    input  wire logic [SAMPLE_W-1:0] sample_in,
    output logic      [OUT_W-1:0]    sample_out,
    output logic                     out_valid,
    input  wire logic                out_ready,
    // history memory port
    output logic                     hist_we,
    output logic      [HIST_AW-1:0]  hist_waddr,
    output logic      [HIST_W-1:0]   hist_wdata,
    output logic      [HIST_AW-1:0]  hist_raddr,
    input  wire logic [HIST_W-1:0]   hist_rdata,
    // control
    input  wire ctrl_cmd_t           cmd,
    output dp_stat_t                 stat
);

    // Configuration registers
    logic [DLY_W-1:0]   max_delay_reg;
    logic [DLY_W-1:0]   first_delay_reg;
    logic [DENS_W-1:0]  tap_density_reg;
    logic [GAIN_W-1:0]  first_gain_reg;
    logic [GAIN_W-1:0]  gain_step_reg;

    // Item state
    logic [SAMPLE_W-1:0] raw_reg;
    logic [HIST_AW-1:0]  wr_idx_reg;
    logic                wrapped_reg;

    // Divider
    logic [DENS_W-1:0]  divisor_reg;
    logic [DENS_W-1:0]  rem_reg;
    logic [DIV_W-1:0]   quot_reg;
    logic [DENS_W:0]    rem_shift;
    logic [DENS_W:0]    rem_diff;
    logic               rem_ge;

    // Tap walk
    logic [DIV_W-1:0]   spacing_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic               in_range;
    logic               written;

    // Tap pipeline
    logic               vld_a_reg;
    logic               ok_a_reg;
    logic [GAIN_W-1:0]  gain_a_reg;
    logic               vld_b_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [TERM_W-1:0] term;
    logic [OUT_W-1:0]   acc_reg;

    logic               out_vld_reg;
    logic [OUT_W-1:0]   out_data_reg;

    // Configuration writes, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_delay_reg   <= RST_MAX_DELAY;
            first_delay_reg <= RST_FIRST_DELAY;
            tap_density_reg <= RST_TAP_DENSITY;
            first_gain_reg  <= RST_FIRST_GAIN;
            gain_step_reg   <= RST_GAIN_STEP;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MAX_DELAY:   max_delay_reg   <= cfg_data[DLY_W-1:0];
                REG_FIRST_DELAY: first_delay_reg <= cfg_data[DLY_W-1:0];
                REG_TAP_DENSITY: tap_density_reg <= cfg_data[DENS_W-1:0];
                REG_FIRST_GAIN:  first_gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_GAIN_STEP:   gain_step_reg   <= cfg_data[GAIN_W-1:0];
                default:         ;
            endcase
        end
    end

    // Capture the input sample
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            raw_reg <= sample_in;
        end
    end

    // Store the centered sample at the write slot
    assign hist_we    = cmd.write_hist;
    assign hist_waddr = wr_idx_reg;
    assign hist_wdata = HIST_W'({1'b0, raw_reg}) - HIST_W'(CENTRE);

    // Advance the write slot; mark the line full after the first wrap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg  <= '0;
            wrapped_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            wr_idx_reg <= wr_idx_reg + 1'b1;
            if (wr_idx_reg == HIST_AW'(HIST_DEPTH - 1))
            begin
                wrapped_reg <= 1'b1;
            end
        end
    end

    // Restoring divider step for 2^FRAC_BITS / density
    assign rem_shift = {rem_reg, quot_reg[DIV_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};
    assign rem_ge    = (rem_shift >= {1'b0, divisor_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            divisor_reg <= (tap_density_reg == '0) ? DENS_W'(1) : tap_density_reg;
            rem_reg     <= '0;
            quot_reg    <= DIV_W'(1) << FRAC_BITS;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_ge ? rem_diff[DENS_W-1:0] : rem_shift[DENS_W-1:0];
            quot_reg <= {quot_reg[DIV_W-2:0], rem_ge};
        end
    end

    // Walk the taps: delay grows by spacing, gain drops and floors at zero
    always_ff @(posedge clk)
    begin
        if (cmd.tap_setup)
        begin
            spacing_reg <= (quot_reg == '0) ? DIV_W'(1) : quot_reg;
            delay_reg   <= DELAY_W'(first_delay_reg);
            gain_reg    <= first_gain_reg;
        end
        else if (cmd.tap_issue)
        begin
            delay_reg <= delay_reg + DELAY_W'(spacing_reg);
            gain_reg  <= (gain_reg > gain_step_reg) ? gain_reg - gain_step_reg : '0;
        end
    end

    // Slot lookup; a slot never written reads as silence
    assign in_range   = (delay_reg < DELAY_W'(HIST_DEPTH));
    assign written    = wrapped_reg || (delay_reg <= DELAY_W'(wr_idx_reg));
    assign hist_raddr = wr_idx_reg - delay_reg[HIST_AW-1:0];

    // Tap pipeline: read, multiply, accumulate
    assign prod_next = $signed({1'b0, gain_a_reg}) *
                       $signed(ok_a_reg ? hist_rdata : HIST_W'(0));
    assign term      = prod_reg[PROD_W-1:FRAC_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else
        begin
            vld_a_reg <= cmd.tap_issue;
            vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_a_reg   <= in_range && written;
        gain_a_reg <= gain_reg;
        prod_reg   <= prod_next;
        if (cmd.tap_setup)
        begin
            acc_reg <= OUT_W'(raw_reg);
        end
        else if (vld_b_reg)
        begin
            acc_reg <= acc_reg + OUT_W'(term);
        end
    end

    // Output register, freed when the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= acc_reg;
        end
    end

    assign out_valid  = out_vld_reg;
    assign sample_out = out_data_reg;

    // Status
    assign stat.tap_active = (delay_reg <= DELAY_W'(max_delay_reg));
    assign stat.pipe_busy  = vld_a_reg || vld_b_reg;
    assign stat.out_free   = !out_vld_reg || out_ready;

endmodule

`default_nettype wire

FILE: design/multi_tap_echo_core.sv
// Multi-tap feed-forward echo: top level joining controller, datapath and
// history RAM. Depends on mte_pkg, mte_ctrl, mte_dp and mte_ram.
//
// Usage:
//   s_* carries one 12-bit offset-binary sample per beat; m_* returns one
//   16-bit result per sample (sample plus echo terms, wrapping mod 2^16).
//   cfg_we/cfg_addr/cfg_data write the five echo registers while idle.
// Processing:
//   An item runs N = (max_delay - first_delay) / spacing + 1 taps, where
//   spacing = 4096 / tap_density; with first_delay > max_delay no tap
//   runs. The spacing divider runs first; then one history read and one
//   multiply-accumulate run per cycle through a 3-stage tap pipeline
//   (read, multiply, accumulate). Up to 4096 taps.
//   One item is in work at a time; s_tready is high only between items.
// Reset:
//   Registers return to their defaults and the delay line reads as silence.
//   Slots not yet written are masked by fill tracking, so no clearing pass.
// Stall:
//   A finished result waits in the output register; the next sample is
//   still taken and processed, and its result waits until m_tready frees it.
`default_nettype none

module multi_tap_echo_core
    import mte_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // input stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [15:0]       s_tdata,    // [11:0] sample_in, [15:12] zero
    // output stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [15:0]       m_tdata,    // [15:0] sample_out
    // configuration
    input  wire logic              cfg_we,
    input  wire logic [CFG_AW-1:0] cfg_addr,
    input  wire logic [CFG_DW-1:0] cfg_data
);

    ctrl_cmd_t           cmd;
    dp_stat_t            stat;
    logic                hist_we;
    logic [HIST_AW-1:0]  hist_waddr;
    logic [HIST_W-1:0]   hist_wdata;
    logic [HIST_AW-1:0]  hist_raddr;
    logic [HIST_W-1:0]   hist_rdata;
    logic [OUT_W-1:0]    sample_out;

    // Sequence each item
    mte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Compute taps and hold the result
    mte_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .sample_in  (s_tdata[SAMPLE_W-1:0]),
        .sample_out (sample_out),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .hist_we    (hist_we),
        .hist_waddr (hist_waddr),
        .hist_wdata (hist_wdata),
        .hist_raddr (hist_raddr),
        .hist_rdata (hist_rdata),
        .cmd        (cmd),
        .stat       (stat)
    );

    // Delay line of centered samples
    mte_ram #(
        .WIDTH (HIST_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    assign m_tdata = sample_out;

`ifndef SYNTHESIS
    // The history write follows every accepted sample
    a_write_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> hist_we)
        else $error("history write missing after input beat");

    // A result is loaded only once the tap pipeline has emptied
    a_load_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !stat.pipe_busy)
        else $error("result loaded with taps in flight");

    // No new sample enters while taps are in flight
    a_accept_idle_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> (!stat.pipe_busy && !hist_we))
        else $error("sample accepted during tap processing");

    // Taps are issued only inside the configured delay window
    a_issue_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tap_issue |-> stat.tap_active)
        else $error("tap issued past the last delay");
`endif

endmodule

`default_nettype wire
